>>> hw/rtl/mmph_pkg.sv
// ----------------------------------------------------------------------------
// mmph_pkg
// Types, algorithm codes and bytewise CRC / checksum functions shared by the
// packet hash engine.
// ----------------------------------------------------------------------------
package mmph_pkg;

  // Algorithm select codes
  localparam logic [1:0] ALG_CRC16_ARC   = 2'd0;
  localparam logic [1:0] ALG_CRC32       = 2'd1;
  localparam logic [1:0] ALG_CRC16_CCITT = 2'd2;
  localparam logic [1:0] ALG_INET_CSUM   = 2'd3;

  // Polynomials and init / final values
  localparam logic [31:0] ARC_POLY_REFL   = 32'h0000_A001;
  localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB8_8320;
  localparam logic [15:0] CCITT_POLY      = 16'h1021;
  localparam logic [31:0] CRC32_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC32_XOR_OUT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CCITT_INIT      = 32'h0000_FFFF;
  localparam logic [31:0] ARC_INIT        = 32'h0000_0000;

  // Running hash state carried between bytes
  typedef struct packed {
    logic [31:0] crc;
    logic [15:0] sum;
    logic        odd;
  } hash_state_t;

  // Reflected (LSB-first) CRC over one byte, eight shift steps
  function automatic logic [31:0] crc_refl_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data,
                                                input logic [31:0] poly);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  // Non-reflected (MSB-first) 16-bit CRC over one byte
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CCITT_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // 16-bit ones-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a,
                                           input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

>>> hw/rtl/mmph_channels.sv
// ----------------------------------------------------------------------------
// mmph channels
// Valid/ready channel interfaces for message bytes and finished hash values.
// ----------------------------------------------------------------------------
interface mmph_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mmph_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

>>> hw/rtl/mmph_core.sv
// ----------------------------------------------------------------------------
// mmph_core
// One-byte update of the running CRC or ones-complement sum, with loading of
// the algorithm's initial value at message start, and the finished value.
// ----------------------------------------------------------------------------
module mmph_core (
  input  logic [1:0]           algorithm,
  input  logic                 mid_message,
  input  mmph_pkg::hash_state_t cur,
  input  logic [7:0]           data_byte,
  output mmph_pkg::hash_state_t nxt,
  output logic [31:0]          result
);

  mmph_pkg::hash_state_t base;
  logic [15:0]           word;
  logic [15:0]           arc_crc;
  logic [15:0]           ccitt_crc;
  logic [31:0]           crc32;

  // First byte of a message starts from the initial value
  always_comb begin
    base = cur;
    if (!mid_message) begin
      unique case (algorithm)
        mmph_pkg::ALG_CRC32:       base.crc = mmph_pkg::CRC32_INIT;
        mmph_pkg::ALG_CRC16_CCITT: base.crc = mmph_pkg::CCITT_INIT;
        default:                   base.crc = mmph_pkg::ARC_INIT;
      endcase
      base.sum = 16'd0;
      base.odd = 1'b0;
    end
  end

  // Byte lands in the high half of a word unless at odd position
  assign word = base.odd ? {8'd0, data_byte} : {data_byte, 8'd0};

  assign arc_crc   = 16'(mmph_pkg::crc_refl_byte({16'd0, base.crc[15:0]}, data_byte,
                                                 mmph_pkg::ARC_POLY_REFL));
  assign crc32     = mmph_pkg::crc_refl_byte(base.crc, data_byte, mmph_pkg::CRC32_POLY_REFL);
  assign ccitt_crc = mmph_pkg::crc_ccitt_byte(base.crc[15:0], data_byte);

  // Select the update for the active algorithm
  always_comb begin
    nxt = base;
    unique case (algorithm)
      mmph_pkg::ALG_CRC16_ARC: begin
        nxt.crc = {16'd0, arc_crc};
        result  = {16'd0, arc_crc};
      end
      mmph_pkg::ALG_CRC32: begin
        nxt.crc = crc32;
        result  = crc32 ^ mmph_pkg::CRC32_XOR_OUT;
      end
      mmph_pkg::ALG_CRC16_CCITT: begin
        nxt.crc = {16'd0, ccitt_crc};
        result  = {16'd0, ccitt_crc};
      end
      mmph_pkg::ALG_INET_CSUM: begin
        nxt.sum = mmph_pkg::ones_add(base.sum, word);
        nxt.odd = ~base.odd;
        result  = {16'd0, ~nxt.sum};
      end
    endcase
  end

endmodule

>>> hw/rtl/multi_mode_packet_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// multi_mode_packet_hash_engine_unit
// CRC-16/ARC, CRC-32, CRC-16/CCITT-FALSE or Internet checksum over a byte
// stream; one hash transaction per message on the last byte.
// ----------------------------------------------------------------------------
//  channel   dir  payload                     transaction
//  msg       in   data_byte[7:0], last_byte   one message byte
//  hash      out  hash_value[31:0]            finished hash of one message
//  cfg_wr_*  in   cfg_wr_data[1:0]            algorithm select, no read-back
//
//  One byte per cycle sustained; the hash of a message passes through the
//  input register, then the result register. The byte update is a single
//  pass through the CRC/sum logic in mmph_core. A stalled hash output holds
//  only a following last byte; other bytes keep flowing. Reset (rst,
//  synchronous) selects CRC-16/ARC and clears the valid flags and hash state.
// ----------------------------------------------------------------------------
module multi_mode_packet_hash_engine_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  mmph_byte_if.sink         msg,
  mmph_hash_if.source       hash
);

  logic [1:0]            algorithm;
  logic                  mid_message;
  mmph_pkg::hash_state_t state;
  mmph_pkg::hash_state_t state_next;
  logic [31:0]           result;

  logic                  s1_valid;
  logic [7:0]            s1_data;
  logic                  s1_last;
  logic                  s1_fire;

  logic                  out_valid;
  logic [31:0]           out_value;

  // Stage 1 moves on unless it has a last byte and a stalled result is held
  assign s1_fire   = s1_valid && (!s1_last || !out_valid || hash.ready);
  assign msg.ready = !s1_valid || s1_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.ready && msg.valid) begin
      s1_data <= msg.data_byte;
      s1_last <= msg.last_byte;
    end
  end

  mmph_core u_core (
    .algorithm   (algorithm),
    .mid_message (mid_message),
    .cur         (state),
    .data_byte   (s1_data),
    .nxt         (state_next),
    .result      (result)
  );

  // Algorithm select and running state; a config write abandons a message
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm   <= mmph_pkg::ALG_CRC16_ARC;
      mid_message <= 1'b0;
      state       <= '0;
    end else if (cfg_wr_en) begin
      algorithm   <= cfg_wr_data;
      mid_message <= 1'b0;
    end else if (s1_fire) begin
      state       <= state_next;
      mid_message <= !s1_last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (hash.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_value <= result;
    end
  end

  assign hash.valid      = out_valid;
  assign hash.hash_value = out_value;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-mode packet hash engine. A directed table
// covers reset state, byte extremes, all four algorithms, checksum padding,
// carry wrap and abandoned messages. Random messages follow in phases with
// different algorithms, random gaps on both channels, a stretch with no gaps and a
// long output stall. Hashes are checked against typed values or a bytewise model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] POLY_ARC_LSB   = 32'h0000_A001;
  localparam logic [31:0] POLY_CRC32_LSB = 32'hEDB8_8320;
  localparam logic [15:0] POLY_CCITT     = 16'h1021;
  localparam int          IDLE_PCT       = 28;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          NUM_PHASES     = 8;
  localparam int          PHASE_BYTES    = 235;
  localparam int          NO_GAP_PHASE   = 4;
  localparam int          STALL_PHASE    = 5;

  typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  alg;
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [31:0] hash;
  } dir_row_t;

  localparam int DIR_ROWS = 30;

  // directed stimulus; hash typed in only where it is obvious
  dir_row_t dir_table [DIR_ROWS] = '{
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_ARC,   8'h00, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_ARC,   8'hFF, 1'b1, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_ARC,   8'h01, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_ARC,   8'h80, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, mmph_pkg::ALG_CRC32,       8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC32,       8'h00, 1'b1, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC32,       8'hFF, 1'b1, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC32,       8'h11, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, mmph_pkg::ALG_CRC32,       8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC32,       8'h22, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, mmph_pkg::ALG_CRC16_CCITT, 8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_CCITT, 8'hA5, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_CCITT, 8'h5A, 1'b1, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_CCITT, 8'hFF, 1'b1, 1'b0, 32'h0},
    '{ROW_WRITE, mmph_pkg::ALG_INET_CSUM,   8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'h00, 1'b1, 1'b1, 32'h0000_FFFF},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'hFF, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'hFF, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'h12, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'h34, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'h56, 1'b1, 1'b1, 32'h0000_97CB},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'hFF, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'hFF, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'h01, 1'b1, 1'b1, 32'h0000_FFFE},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'hAB, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, mmph_pkg::ALG_INET_CSUM,   8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_INET_CSUM,   8'hCD, 1'b1, 1'b1, 32'h0000_32FF},
    '{ROW_WRITE, mmph_pkg::ALG_CRC16_ARC,   8'h00, 1'b0, 1'b0, 32'h0},
    '{ROW_BYTE,  mmph_pkg::ALG_CRC16_ARC,   8'h7E, 1'b1, 1'b0, 32'h0}
  };

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  mmph_byte_if msg_ch ();
  mmph_hash_if hash_ch ();

  multi_mode_packet_hash_engine_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .msg         (msg_ch),
    .hash        (hash_ch)
  );

  // hashes still owed by the block, oldest first
  logic [31:0] hash_expect_q [$];
  int          err_count  = 0;
  int          bytes_sent = 0;
  logic        idle_on    = 1'b1;
  logic        hold_req   = 1'b0;

  // model state
  logic [1:0]  cur_alg   = mmph_pkg::ALG_CRC16_ARC;
  logic [31:0] run_crc   = '0;
  logic [15:0] run_sum   = '0;
  logic        low_half  = 1'b0;
  logic        msg_open  = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  // LSB-first CRC over one byte, one feedback bit per data bit
  function automatic logic [31:0] lsb_crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                               input logic [31:0] poly);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ poly;
    end
    return c;
  endfunction

  // MSB-first 16-bit CRC over one byte
  function automatic logic [15:0] msb_crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = c << 1;
      if (fb) c = c ^ POLY_CCITT;
    end
    return c;
  endfunction

  function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // advance the model by one accepted byte; got is set on the last byte
  task automatic hash_of_byte(input logic [7:0] b, input logic fin,
                              output logic got, output logic [31:0] val);
    if (!msg_open) begin
      case (cur_alg)
        mmph_pkg::ALG_CRC32:       run_crc = 32'hFFFF_FFFF;
        mmph_pkg::ALG_CRC16_CCITT: run_crc = 32'h0000_FFFF;
        default:                   run_crc = 32'h0000_0000;
      endcase
      run_sum  = '0;
      low_half = 1'b0;
      msg_open = 1'b1;
    end
    case (cur_alg)
      mmph_pkg::ALG_CRC16_ARC: begin
        run_crc = lsb_crc_byte(run_crc & 32'h0000_FFFF, b, POLY_ARC_LSB) & 32'h0000_FFFF;
        val     = run_crc;
      end
      mmph_pkg::ALG_CRC32: begin
        run_crc = lsb_crc_byte(run_crc, b, POLY_CRC32_LSB);
        val     = ~run_crc;
      end
      mmph_pkg::ALG_CRC16_CCITT: begin
        run_crc = {16'd0, msb_crc16_byte(run_crc[15:0], b)};
        val     = run_crc;
      end
      default: begin
        // bytes pair up big-endian; a lone last byte is the high half
        run_sum  = ones_sum16(run_sum, low_half ? {8'd0, b} : {b, 8'd0});
        low_half = ~low_half;
        val      = {16'd0, ~run_sum};
      end
    endcase
    got = fin;
    if (fin) msg_open = 1'b0;
  endtask

  // offer one byte, with random gaps, and predict once it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin,
                           input logic typed, input logic [31:0] typed_hash);
    logic        got;
    logic [31:0] val;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      msg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    msg_ch.valid     <= 1'b1;
    msg_ch.data_byte <= b;
    msg_ch.last_byte <= fin;
    do @(posedge clk); while (!msg_ch.ready);
    hash_of_byte(b, fin, got, val);
    if (got) hash_expect_q.push_back(typed ? typed_hash : val);
    bytes_sent++;
  endtask

  // algorithm select, only once the block has drained
  task automatic write_algorithm(input logic [1:0] alg);
    msg_ch.valid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= alg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_alg  = alg;
    msg_open = 1'b0;
  endtask

  // one random message; some are all zero or all ones
  task automatic send_message();
    int len;
    int fill;
    len  = ($urandom_range(7) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 1);
    fill = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      send_byte((fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom_range(255)),
                i == len - 1, 1'b0, 32'd0);
    end
  endtask

  // hash sink: checks each transaction, drives ready with gaps and the long stall
  initial begin : hash_sink
    int          hold_left;
    logic [31:0] want;
    hold_left     = 0;
    hash_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hash_ch.valid && hash_ch.ready) begin
        if (hash_expect_q.size() == 0) begin
          $display("%0t: unexpected hash transaction, expected none, actual %08h",
                   $time, hash_ch.hash_value);
          err_count++;
        end else begin
          want = hash_expect_q.pop_front();
          if (hash_ch.hash_value !== want) begin
            $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                     $time, want, hash_ch.hash_value);
            err_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        hash_ch.ready <= 1'b0;
      end else begin
        hash_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [1:0] phase_alg;
    int         phase_end;
    int         nparts;
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = mmph_pkg::ALG_CRC16_ARC;
    msg_ch.valid     = 1'b0;
    msg_ch.data_byte = '0;
    msg_ch.last_byte = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].kind == ROW_WRITE) begin
        write_algorithm(dir_table[r].alg);
      end else begin
        send_byte(dir_table[r].data, dir_table[r].fin, dir_table[r].typed, dir_table[r].hash);
      end
    end

    // random phases, each under its own algorithm
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       phase_alg = mmph_pkg::ALG_CRC16_ARC;
        1:       phase_alg = mmph_pkg::ALG_CRC32;
        2:       phase_alg = mmph_pkg::ALG_CRC16_CCITT;
        3:       phase_alg = mmph_pkg::ALG_INET_CSUM;
        4:       phase_alg = mmph_pkg::ALG_INET_CSUM;
        5:       phase_alg = mmph_pkg::ALG_CRC32;
        default: phase_alg = 2'($urandom_range(3));
      endcase
      // sometimes leave a message open so the write abandons it
      if ($urandom_range(1) == 1) begin
        nparts = $urandom_range(3, 1);
        for (int i = 0; i < nparts; i++) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, 32'd0);
      end
      write_algorithm(phase_alg);
      idle_on = (ph != NO_GAP_PHASE) && (ph != STALL_PHASE);
      if (ph == STALL_PHASE) hold_req = 1'b1;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_message();
      idle_on = 1'b1;
    end

    // drain
    msg_ch.valid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
